// ===== sv/nsp_pkg.sv =====
// Shared types, constants and tables for the stencil peak rate block.
`default_nettype none
package nsp_pkg;

  localparam int CordicStepsDef = 16;
  localparam int CordicStepsMax = 24;
  localparam logic signed [33:0] CordicGain = 34'sd652032874;

  // Controller states; the datapath operation follows the state.
  typedef enum logic [4:0] {
    S_IDLE, S_CORDIC, S_MRE, S_MIM, S_DRE, S_DIM, S_D15, S_GMUL, S_GRND,
    S_KLO, S_KHI, S_KSUM, S_CLMP, S_SQ, S_SQACC, S_SHIFT, S_SQINIT, S_SQRT,
    S_EMIT
  } state_e;

  typedef enum logic [4:0] {
    OP_NONE, OP_LOAD, OP_CORDIC, OP_MRE, OP_MIM, OP_DRE, OP_DIM, OP_D15,
    OP_GMUL, OP_GRND, OP_KLO, OP_KHI, OP_KSUM, OP_CLMP, OP_SQ, OP_SQACC,
    OP_SHIFT, OP_SQINIT, OP_SQRT, OP_EMIT
  } op_e;

  typedef struct packed {
    op_e  op;
    logic im;   // imaginary component of the stencil pass
  } cmd_t;

  typedef struct packed {
    logic       cordic_done;
    logic       sqrt_done;
    logic       full;
    logic       last;
    logic       out_busy;
    logic [1:0] count;
  } sts_t;

  // atan(2^-i) as a fraction of a turn, scaled by 2^32
  function automatic logic [29:0] atan_turn(input logic [4:0] idx);
    logic [29:0] r;
    case (idx)
      5'd0:  r = 30'd536870912;
      5'd1:  r = 30'd316933406;
      5'd2:  r = 30'd167458907;
      5'd3:  r = 30'd85004756;
      5'd4:  r = 30'd42667331;
      5'd5:  r = 30'd21354465;
      5'd6:  r = 30'd10679838;
      5'd7:  r = 30'd5340245;
      5'd8:  r = 30'd2670163;
      5'd9:  r = 30'd1335087;
      5'd10: r = 30'd667544;
      5'd11: r = 30'd333772;
      5'd12: r = 30'd166886;
      5'd13: r = 30'd83443;
      5'd14: r = 30'd41722;
      5'd15: r = 30'd20861;
      5'd16: r = 30'd10430;
      5'd17: r = 30'd5215;
      5'd18: r = 30'd2608;
      5'd19: r = 30'd1304;
      5'd20: r = 30'd652;
      5'd21: r = 30'd326;
      5'd22: r = 30'd163;
      5'd23: r = 30'd81;
      default: r = 30'd0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== sv/nsp_if.sv =====
// Request channels: sample input, result output and coupling write.
`default_nettype none
interface nsp_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] amplitude;
  logic        [15:0] phase;
  logic               last;
  modport source (output valid, amplitude, phase, last, input ready);
  modport sink   (input valid, amplitude, phase, last, output ready);
endinterface

interface nsp_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] peak_rate;
  modport source (output valid, peak_rate, input ready);
  modport sink   (input valid, peak_rate, output ready);
endinterface

interface nsp_cfg_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] coupling;
  modport source (output valid, coupling, input ready);
  modport sink   (input valid, coupling, output ready);
endinterface
`default_nettype wire

// ===== sv/nsp_ctrl.sv =====
// Sequencer for the stencil peak rate datapath.
`default_nettype none
module nsp_ctrl import nsp_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   in_valid_i,
  output logic   in_ready_o,
  input  sts_t   sts_i,
  output cmd_t   cmd_o,
  output state_e state_o
);

  state_e state_q, state_d;
  logic   im_q, im_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      im_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      im_q    <= im_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    im_d       = im_q;
    cmd_o.op   = OP_NONE;
    cmd_o.im   = im_q;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.op = OP_LOAD;
          im_d     = 1'b0;
          state_d  = S_CORDIC;
        end
      end
      S_CORDIC: begin
        cmd_o.op = OP_CORDIC;
        if (sts_i.cordic_done) state_d = S_MRE;
      end
      S_MRE: begin
        cmd_o.op = OP_MRE;
        state_d  = S_MIM;
      end
      S_MIM: begin
        cmd_o.op = OP_MIM;
        state_d  = S_DRE;
      end
      S_DRE: begin
        cmd_o.op = OP_DRE;
        state_d  = sts_i.full ? S_DIM : S_SHIFT;
      end
      S_DIM: begin
        cmd_o.op = OP_DIM;
        state_d  = S_D15;
      end
      S_D15: begin
        cmd_o.op = OP_D15;
        state_d  = S_GMUL;
      end
      S_GMUL: begin
        cmd_o.op = OP_GMUL;
        state_d  = S_GRND;
      end
      S_GRND: begin
        cmd_o.op = OP_GRND;
        state_d  = S_KLO;
      end
      S_KLO: begin
        cmd_o.op = OP_KLO;
        state_d  = S_KHI;
      end
      S_KHI: begin
        cmd_o.op = OP_KHI;
        state_d  = S_KSUM;
      end
      S_KSUM: begin
        cmd_o.op = OP_KSUM;
        state_d  = S_CLMP;
      end
      S_CLMP: begin
        cmd_o.op = OP_CLMP;
        state_d  = S_SQ;
      end
      S_SQ: begin
        cmd_o.op = OP_SQ;
        state_d  = S_SQACC;
      end
      S_SQACC: begin
        cmd_o.op = OP_SQACC;
        if (im_q) begin
          state_d = S_SHIFT;
        end else begin
          im_d    = 1'b1;
          state_d = S_GMUL;
        end
      end
      S_SHIFT: begin
        cmd_o.op = OP_SHIFT;
        state_d  = sts_i.last ? S_SQINIT : S_IDLE;
      end
      S_SQINIT: begin
        cmd_o.op = OP_SQINIT;
        state_d  = S_SQRT;
      end
      S_SQRT: begin
        cmd_o.op = OP_SQRT;
        if (sts_i.sqrt_done) state_d = S_EMIT;
      end
      S_EMIT: begin
        // wait for the output register to drain
        if (!sts_i.out_busy) begin
          cmd_o.op = OP_EMIT;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign state_o = state_q;

endmodule
`default_nettype wire

// ===== sv/nsp_dp.sv =====
// Datapath: CORDIC, shared multiplier, stencil arithmetic and square root.
`default_nettype none
module nsp_dp import nsp_pkg::*; #(
  parameter int CORDIC_STEPS = CordicStepsDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cmd_t               cmd_i,
  output sts_t               sts_o,
  input  logic signed [15:0] amplitude_i,
  input  logic        [15:0] phase_i,
  input  logic               last_i,
  input  logic               cfg_we_i,
  input  logic signed [31:0] coupling_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic        [31:0] peak_rate_o
);

  localparam int StepsEff = (CORDIC_STEPS > CordicStepsMax) ? CordicStepsMax : CORDIC_STEPS;
  localparam int IterW    = $clog2(StepsEff + 1);
  localparam logic [IterW-1:0] IterLast = IterW'(StepsEff - 1);

  function automatic logic signed [16:0] cs_round(input logic signed [33:0] v,
                                                  input logic flip);
    logic signed [34:0] t;
    logic signed [16:0] c;
    t = (35'(v) + 35'sd16384) >>> 15;
    if (t > 35'sd32768)       c = 17'sd32768;
    else if (t < -35'sd32768) c = -17'sd32768;
    else                      c = 17'(t);
    return flip ? -c : c;
  endfunction

  // CORDIC state
  logic signed [33:0] x_q, y_q, z_q;
  logic [IterW-1:0]   iter_q;
  logic               flip_q;
  logic signed [15:0] amp_q;
  logic               last_q;
  // series state
  logic signed [23:0] w_re_q [2];
  logic signed [23:0] w_im_q [2];
  logic [1:0]         count_q;
  logic [63:0]        peak_q;
  logic signed [31:0] coupling_q;
  // intermediates
  logic [63:0]        prod_q;
  logic               pneg_q;
  logic [63:0]        acc_q, acc2_q;
  logic signed [23:0] nre_q, nim_q;
  logic [31:0]        d15_q;
  logic signed [38:0] g_q;
  logic signed [47:0] kp_q;
  logic signed [32:0] s_q;
  // square root
  logic [63:0]        v_q, r_q, bit_q;
  logic               sat_q;
  logic               out_valid_q;
  logic [31:0]        out_q;

  logic signed [16:0] cs_re, cs_im;
  logic signed [23:0] c_cur, n_cur, p_cur;
  logic [22:0]        c_mag;
  logic [37:0]        g_mag;
  logic [31:0]        k_mag, s_mag;
  logic [15:0]        amp_mag, csr_mag, csi_mag;
  logic signed [64:0] pval;
  logic [31:0]        ma, mb;
  logic [63:0]        mp;
  logic               mneg;
  logic [31:0]        ang, ang_t, ang_z;
  logic signed [33:0] sx, sy;
  logic [29:0]        atn;
  logic [69:0]        ksum;
  logic [62:0]        ksat;
  logic signed [63:0] ksgn;
  logic signed [48:0] lap_sum;
  logic signed [26:0] lap;
  logic [63:0]        mag, sq_rb;

  assign cs_re   = cs_round(x_q, flip_q);
  assign cs_im   = cs_round(y_q, flip_q);
  assign amp_mag = amp_q[15] ? 16'(-amp_q) : 16'(amp_q);
  assign csr_mag = cs_re[16] ? 16'(-cs_re) : 16'(cs_re);
  assign csi_mag = cs_im[16] ? 16'(-cs_im) : 16'(cs_im);
  assign c_cur   = cmd_i.im ? w_im_q[1] : w_re_q[1];
  assign p_cur   = cmd_i.im ? w_im_q[0] : w_re_q[0];
  assign n_cur   = cmd_i.im ? nim_q : nre_q;
  assign c_mag   = c_cur[23] ? 23'(-c_cur) : 23'(c_cur);
  assign g_mag   = g_q[38] ? 38'(-g_q) : 38'(g_q);
  assign k_mag   = coupling_q[31] ? 32'(-33'(coupling_q)) : 32'(coupling_q);
  assign s_mag   = s_q[32] ? 32'(-s_q) : 32'(s_q);
  assign pval    = pneg_q ? -$signed({1'b0, prod_q}) : $signed({1'b0, prod_q});

  // operand select for the shared unsigned multiplier
  always_comb begin
    ma   = '0;
    mb   = '0;
    mneg = 1'b0;
    case (cmd_i.op)
      OP_MRE: begin
        ma = 32'(amp_mag); mb = 32'(csr_mag); mneg = amp_q[15] ^ cs_re[16];
      end
      OP_MIM: begin
        ma = 32'(amp_mag); mb = 32'(csi_mag); mneg = amp_q[15] ^ cs_im[16];
      end
      OP_DRE, OP_DIM: begin
        ma = 32'(c_mag); mb = 32'(c_mag);
        if (cmd_i.op == OP_DIM) begin
          ma = 32'(w_im_q[1][23] ? 23'(-w_im_q[1]) : 23'(w_im_q[1]));
          mb = ma;
        end else begin
          ma = 32'(w_re_q[1][23] ? 23'(-w_re_q[1]) : 23'(w_re_q[1]));
          mb = ma;
        end
      end
      OP_GMUL: begin
        ma = d15_q; mb = 32'(c_mag); mneg = c_cur[23];
      end
      OP_KLO: begin
        ma = k_mag; mb = 32'(g_mag[18:0]); mneg = coupling_q[31] ^ g_q[38];
      end
      OP_KHI: begin
        ma = k_mag; mb = 32'(g_mag[37:19]); mneg = pneg_q;
      end
      OP_SQ: begin
        ma = s_mag; mb = s_mag;
      end
      default: ;
    endcase
  end

  assign mp = 64'(ma) * 64'(mb);

  assign ang   = {phase_i, 16'h0000};
  assign ang_t = ang + 32'h4000_0000;
  assign ang_z = ang_t[31] ? ang + 32'h8000_0000 : ang;
  assign sx    = x_q >>> iter_q;
  assign sy    = y_q >>> iter_q;
  assign atn   = atan_turn(5'(iter_q));

  // coupling product: magnitude of the two partial products, saturated at 2^62
  assign ksum = {6'b0, acc_q} + ({6'b0, prod_q} << 19);
  assign ksat = (ksum > 70'h0_4000_0000_0000_0000) ? 63'h4000_0000_0000_0000 : ksum[62:0];
  assign ksgn = pneg_q ? -$signed({1'b0, ksat}) : $signed({1'b0, ksat});
  assign lap  = 27'(n_cur) - (27'(c_cur) <<< 1) + 27'(p_cur);
  assign lap_sum = 49'(lap) + 49'(kp_q);
  assign mag   = acc2_q + prod_q;
  assign sq_rb = r_q + bit_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.op != OP_NONE && cmd_i.op != OP_LOAD) begin
      prod_q <= mp;
      pneg_q <= mneg;
    end
    case (cmd_i.op)
      OP_LOAD: begin
        amp_q  <= amplitude_i;
        last_q <= last_i;
        flip_q <= ang_t[31];
        z_q    <= 34'($signed(ang_z));
        x_q    <= CordicGain;
        y_q    <= '0;
      end
      OP_CORDIC: begin
        if (!z_q[33]) begin
          x_q <= x_q - sy;
          y_q <= y_q + sx;
          z_q <= z_q - 34'(atn);
        end else begin
          x_q <= x_q + sy;
          y_q <= y_q - sx;
          z_q <= z_q + 34'(atn);
        end
      end
      OP_MIM:  nre_q <= 24'((pval + 65'sd128) >>> 8);
      OP_DRE:  nim_q <= 24'((pval + 65'sd128) >>> 8);
      OP_DIM:  acc_q <= prod_q;
      OP_D15:  d15_q <= 32'((48'(acc_q) + 48'(prod_q) + 48'd16384) >> 15);
      OP_GRND: g_q   <= 39'((pval + 65'sd16384) >>> 15);
      OP_KHI:  acc_q <= prod_q;
      OP_KSUM: kp_q  <= 48'((65'(ksgn) + 65'sd32768) >>> 16);
      OP_CLMP: begin
        if (lap_sum > 49'sd2147483648)       s_q <= 33'sd2147483647 + 33'sd1;
        else if (lap_sum < -49'sd2147483648) s_q <= -33'sd2147483647 - 33'sd1;
        else                                 s_q <= 33'(lap_sum);
      end
      OP_SQACC: if (!cmd_i.im) acc2_q <= prod_q;
      OP_SQINIT: begin
        sat_q <= |peak_q[63:62];
        v_q   <= peak_q << 2;
        r_q   <= '0;
        bit_q <= 64'h4000_0000_0000_0000;
      end
      OP_SQRT: begin
        if (v_q >= sq_rb) begin
          v_q <= v_q - sq_rb;
          r_q <= (r_q >> 1) + bit_q;
        end else begin
          r_q <= r_q >> 1;
        end
        bit_q <= bit_q >> 2;
      end
      OP_EMIT: out_q <= sat_q ? '1 : r_q[31:0];
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      iter_q      <= '0;
      count_q     <= '0;
      peak_q      <= '0;
      coupling_q  <= '0;
      out_valid_q <= 1'b0;
      w_re_q[0]   <= '0;
      w_re_q[1]   <= '0;
      w_im_q[0]   <= '0;
      w_im_q[1]   <= '0;
    end else begin
      if (cfg_we_i) coupling_q <= coupling_i;
      if (out_valid_q && out_ready_i) out_valid_q <= 1'b0;
      case (cmd_i.op)
        OP_LOAD:   iter_q <= '0;
        OP_CORDIC: iter_q <= iter_q + 1'b1;
        OP_SQACC: begin
          if (cmd_i.im && mag > peak_q) peak_q <= mag;
        end
        OP_SHIFT: begin
          w_re_q[0] <= w_re_q[1];
          w_im_q[0] <= w_im_q[1];
          w_re_q[1] <= nre_q;
          w_im_q[1] <= nim_q;
          if (count_q != 2'd2) count_q <= count_q + 2'd1;
        end
        OP_SQINIT: begin
          w_re_q[0] <= '0;
          w_re_q[1] <= '0;
          w_im_q[0] <= '0;
          w_im_q[1] <= '0;
          count_q   <= '0;
          peak_q    <= '0;
        end
        OP_EMIT: out_valid_q <= 1'b1;
        default: ;
      endcase
    end
  end

  assign sts_o.cordic_done = (iter_q == IterLast);
  assign sts_o.sqrt_done   = bit_q[0];
  assign sts_o.full        = (count_q == 2'd2);
  assign sts_o.last        = last_q;
  assign sts_o.out_busy    = out_valid_q;
  assign sts_o.count       = count_q;
  assign out_valid_o       = out_valid_q;
  assign peak_rate_o       = out_q;

endmodule
`default_nettype wire

// ===== sv/nlse_stencil_peak_rate_core.sv =====
// Top level of the nonlinear wave stencil peak rate block.
// Each sample is rotated by an iterative CORDIC (one step a cycle), then a
// single shared 32x32 multiplier works through the stencil terms one product
// per cycle. Until two samples are held a sample is only rotated, scaled and
// shifted in; after that its real and imaginary stencil terms come first. The
// sample marked last adds the bit-pair square root (32 steps) and the load of
// the output register. One sample is in work at a time; the result register
// lets the next series start while a result still waits to be taken. The
// coupling register can be written at any time the block is idle.
`default_nettype none
module nlse_stencil_peak_rate_core import nsp_pkg::*; #(
  parameter int CORDIC_STEPS = CordicStepsDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  nsp_in_if.sink    in_i,
  nsp_out_if.source out_o,
  nsp_cfg_if.sink   cfg_i
);

  cmd_t   cmd;
  sts_t   sts;
  state_e state;

  assign cfg_i.ready = 1'b1;

  nsp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd),
    .state_o    (state)
  );

  nsp_dp #(
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .amplitude_i (in_i.amplitude),
    .phase_i     (in_i.phase),
    .last_i      (in_i.last),
    .cfg_we_i    (cfg_i.valid),
    .coupling_i  (cfg_i.coupling),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .peak_rate_o (out_o.peak_rate)
  );

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.valid && in_i.ready |=> !in_i.ready)
    else $error("input taken while a request is in work");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sts.count != 2'd3)
    else $error("sample count overflow");

  a_emit_in_place: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.op == OP_EMIT |-> state == S_EMIT && !out_o.valid)
    else $error("result loaded over a pending result");

endmodule
`default_nettype wire

// ===== tb/nlse_stencil_peak_rate_core_tb.sv =====
// Testbench for the stencil peak rate block: random series against a behavioral predictor.
`timescale 1ns / 1ps
module nlse_stencil_peak_rate_core_tb;
  import nsp_pkg::*;

  localparam int Steps = CordicStepsDef;
  localparam longint ProdLim = 64'sh4000000000000000;
  localparam longint PsiLim = 64'sh80000000;

  // Predictor of the block plus the queue of expected peak rates.
  class peak_rate_board;
    longint wre[2], wim[2];
    int unsigned held;
    logic [63:0] peak_sq;
    logic [31:0] coupling;
    logic [31:0] pending[$];
    int errors;

    function new();
      clear_series();
      coupling = '0;
      errors = 0;
    endfunction

    function void clear_series();
      wre[0] = 0; wre[1] = 0; wim[0] = 0; wim[1] = 0;
      held = 0; peak_sq = 0;
    endfunction

    function longint asr(longint v, int s);
      return v >>> s;
    endfunction

    function longint rshr(longint v, int s);
      return (v + (longint'(1) <<< (s - 1))) >>> s;
    endfunction

    function longint clampv(longint v, longint lim);
      if (v > lim) return lim;
      if (v < -lim) return -lim;
      return v;
    endfunction

    function longint mul_sat(longint a, longint b);
      logic [63:0] ua, ub;
      logic [127:0] p;
      bit neg;
      if (a == 0 || b == 0) return 0;
      neg = (a < 0) != (b < 0);
      ua = a < 0 ? -a : a;
      ub = b < 0 ? -b : b;
      p = ua * ub;
      if (p > ProdLim) return neg ? -ProdLim : ProdLim;
      return neg ? -longint'(p[63:0]) : longint'(p[63:0]);
    endfunction

    function logic [63:0] root(logic [63:0] v);
      logic [63:0] r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
        if (v >= r + b) begin
          v -= r + b;
          r = (r >> 1) + b;
        end else begin
          r >>= 1;
        end
        b >>= 2;
      end
      return r;
    endfunction

    function void rotate(logic [15:0] ph, output longint c, output longint s);
      logic [31:0] ang;
      bit flip;
      longint x, y, z, nx;
      ang = {ph, 16'd0};
      flip = ang[31] ^ ang[30];
      if (flip) ang += 32'h80000000;
      z = longint'($signed(ang));
      x = longint'(CordicGain);
      y = 0;
      for (int i = 0; i < Steps; i++) begin
        if (z >= 0) begin
          nx = x - asr(y, i); y = y + asr(x, i); z -= longint'(atan_turn(5'(i)));
        end else begin
          nx = x + asr(y, i); y = y - asr(x, i); z += longint'(atan_turn(5'(i)));
        end
        x = nx;
      end
      x = clampv(rshr(x, 15), 32768);
      y = clampv(rshr(y, 15), 32768);
      c = flip ? -x : x;
      s = flip ? -y : y;
    endfunction

    function void close_stencil(longint nre, longint nim);
      longint cre, cim, lre, lim, d15, k, gre, gim, sre, sim;
      logic [63:0] dens, mag;
      cre = wre[1]; cim = wim[1];
      lre = nre - 2 * cre + wre[0];
      lim = nim - 2 * cim + wim[0];
      dens = cre * cre + cim * cim;
      d15 = longint'((dens + 16384) >> 15);
      k = longint'($signed(coupling));
      gre = rshr(d15 * cre, 15);
      gim = rshr(d15 * cim, 15);
      sre = clampv(lre + rshr(mul_sat(k, gre), 16), PsiLim);
      sim = clampv(lim + rshr(mul_sat(k, gim), 16), PsiLim);
      mag = sre * sre + sim * sim;
      if (mag > peak_sq) peak_sq = mag;
    endfunction

    function void note_sample(logic [15:0] amp, logic [15:0] ph, logic lst);
      longint c, s, nre, nim, a;
      logic [63:0] r;
      a = longint'($signed(amp));
      rotate(ph, c, s);
      nre = rshr(a * c, 8);
      nim = rshr(a * s, 8);
      if (held >= 2) close_stencil(nre, nim);
      wre[0] = wre[1]; wim[0] = wim[1];
      wre[1] = nre; wim[1] = nim;
      if (held < 2) held++;
      if (lst) begin
        if (peak_sq >= ProdLim) pending.push_back(32'hFFFFFFFF);
        else begin
          r = root(peak_sq << 2);
          pending.push_back(r[31:0]);
        end
        clear_series();
      end
    endfunction

    function void check_rate(logic [31:0] got);
      logic [31:0] want;
      if (pending.size() == 0) begin
        $display("%0t: unexpected peak_rate %h", $time, got);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (want !== got) begin
        $display("%0t: peak_rate expected %h actual %h", $time, want, got);
        errors++;
      end
    endfunction
  endclass

  logic clk_i = 0, rst_ni = 0;
  nsp_in_if in_ch();
  nsp_out_if out_ch();
  nsp_cfg_if cfg_ch();
  peak_rate_board board = new();
  bit hold_off = 0;
  bit stall_on = 1;

  nlse_stencil_peak_rate_core u_top (
    .clk_i(clk_i), .rst_ni(rst_ni), .in_i(in_ch.sink), .out_o(out_ch.source),
    .cfg_i(cfg_ch.sink)
  );

  always begin
    #5 clk_i = 1;
    #5 clk_i = 0;
  end

  initial begin
    in_ch.valid = 0; in_ch.amplitude = 0; in_ch.phase = 0; in_ch.last = 0;
    out_ch.ready = 0;
    cfg_ch.valid = 0; cfg_ch.coupling = 0;
  end

  // Accepted requests on both sides feed the scoreboard.
  always @(posedge clk_i) begin
    if (rst_ni && in_ch.valid && in_ch.ready)
      board.note_sample(in_ch.amplitude, in_ch.phase, in_ch.last);
    if (rst_ni && out_ch.valid && out_ch.ready)
      board.check_rate(out_ch.peak_rate);
  end

  // Receiver stall pattern; hold_off forces a long stall.
  always @(posedge clk_i) begin
    if (hold_off) out_ch.ready <= 0;
    else if (!stall_on) out_ch.ready <= 1;
    else out_ch.ready <= ($urandom_range(0, 3) != 0);
  end

  task automatic write_coupling(logic [31:0] v);
    cfg_ch.valid <= 1;
    cfg_ch.coupling <= v;
    do @(posedge clk_i); while (!cfg_ch.ready);
    board.coupling = v;
    cfg_ch.valid <= 0;
  endtask

  task automatic send(logic [15:0] amp, logic [15:0] ph, logic lst);
    in_ch.valid <= 1;
    in_ch.amplitude <= amp;
    in_ch.phase <= ph;
    in_ch.last <= lst;
    do @(posedge clk_i); while (!in_ch.ready);
  endtask

  task automatic gap(int n);
    if (n > 0) begin
      in_ch.valid <= 0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  task automatic drain();
    in_ch.valid <= 0;
    while (board.pending.size() != 0) @(posedge clk_i);
    repeat (120) @(posedge clk_i);
  endtask

  function automatic logic [15:0] rand_amp();
    case ($urandom_range(0, 5))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'($signed($urandom_range(0, 1024)) - 512);
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic random_series(int len, int burst_gap);
    for (int i = 0; i < len; i++) begin
      send(rand_amp(), 16'($urandom), i == len - 1);
      if ($urandom_range(0, 5) == 0) gap($urandom_range(1, burst_gap));
    end
  endtask

  logic [31:0] couplings[6] = '{32'h0, 32'h7FFFFFFF, 32'h80000000, 32'h00010000,
                                32'hFFFF0000, 32'h00000100};

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);
    // Directed: short runs, extreme amplitudes, quadrant phases.
    send(16'h7FFF, 16'h0000, 1);
    send(16'h8000, 16'h4000, 0); send(16'h7FFF, 16'h8000, 1);
    send(16'h7FFF, 16'h0000, 0); send(16'h8000, 16'h8000, 0);
    send(16'h7FFF, 16'hC000, 0); send(16'h8000, 16'hFFFF, 1);
    send(16'h0000, 16'h2000, 0); send(16'h0000, 16'h6000, 0);
    send(16'h0000, 16'hA000, 1);
    drain();
    write_coupling(32'h7FFFFFFF);
    // Huge rate: big amplitudes with maximal coupling.
    send(16'h7FFF, 16'h0000, 0); send(16'h7FFF, 16'h0000, 0);
    send(16'h8000, 16'h8000, 0); send(16'h7FFF, 16'h4000, 1);
    drain();
    // Long receiver hold-off while the sender keeps going.
    hold_off = 1;
    fork
      begin
        for (int k = 0; k < 12; k++) random_series(3, 2);
      end
      begin
        repeat (2000) @(posedge clk_i);
        hold_off = 0;
      end
    join
    drain();
    for (int ph = 0; ph < 6; ph++) begin
      write_coupling(ph == 5 ? 32'($urandom) : couplings[ph]);
      stall_on = (ph != 2);
      for (int s = 0; s < 50; s++) begin
        random_series($urandom_range(1, 8), (ph == 3) ? 1 : 30);
        if ($urandom_range(0, 3) == 0) gap($urandom_range(1, 40));
      end
      drain();
    end
    if (board.errors == 0 && board.pending.size() == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

  initial begin
    #20ms;
    $display("simulation failed");
    $finish;
  end
endmodule
